// ----- src/slcfr_pkg.sv -----
// ----------------------------------------------------------------------------
// slcfr_pkg
// Shared types, codes and the CRC-16/CCITT-FALSE byte update for the receiver.
// ----------------------------------------------------------------------------
`default_nettype none
package slcfr_pkg;

   localparam int unsigned HDR_LEN = 5;
   localparam int unsigned CRC_LEN = 2;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;
   localparam logic [15:0] CRC_MSB = 16'h8000;

   localparam logic [7:0] SYNC1_RST = 8'hAA;
   localparam logic [7:0] SYNC2_RST = 8'h55;
   localparam logic [7:0] FTYPE_RST = 8'h01;
   localparam logic [5:0] PLEN_RST = 6'd11;

   typedef enum logic [1:0] {
      REG_SYNC1 = 2'd0,
      REG_SYNC2 = 2'd1,
      REG_FTYPE = 2'd2,
      REG_PLEN  = 2'd3
   } reg_idx_type;

   typedef struct packed {
      logic [7:0] sync1;
      logic [7:0] sync2;
      logic [7:0] ftype;
      logic [5:0] plen;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_READ,
      ST_EVAL,
      ST_EREAD,
      ST_EOUT
   } state_type;

   typedef enum logic [2:0] {
      ACT_WAIT,
      ACT_NEXT,
      ACT_DROP,
      ACT_DONE,
      ACT_EMIT,
      ACT_REMOVE
   } act_type;

   function automatic logic [15:0] crc16_upd(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if ((c & CRC_MSB) != 16'h0000) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage
`default_nettype wire

// ----- src/slcfr_ram.sv -----
// ----------------------------------------------------------------------------
// slcfr_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module slcfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 39
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule
`default_nettype wire

// ----- src/slcfr_csr.sv -----
// ----------------------------------------------------------------------------
// slcfr_csr
// APB-style register file: sync bytes, frame type and payload length.
// ----------------------------------------------------------------------------
`default_nettype none
module slcfr_csr (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready,
   output slcfr_pkg::cfg_type cfg
);

   slcfr_pkg::cfg_type cfg_ff, cfg_in;
   slcfr_pkg::reg_idx_type sel;
   logic wr;

   assign csr_pready = 1'b1;
   assign sel = slcfr_pkg::reg_idx_type'(csr_paddr[3:2]);
   assign wr = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (sel)
            slcfr_pkg::REG_SYNC1: cfg_in.sync1 = csr_pwdata[7:0];
            slcfr_pkg::REG_SYNC2: cfg_in.sync2 = csr_pwdata[7:0];
            slcfr_pkg::REG_FTYPE: cfg_in.ftype = csr_pwdata[7:0];
            slcfr_pkg::REG_PLEN:  cfg_in.plen  = csr_pwdata[5:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (sel)
         slcfr_pkg::REG_SYNC1: csr_prdata = {24'h0, cfg_ff.sync1};
         slcfr_pkg::REG_SYNC2: csr_prdata = {24'h0, cfg_ff.sync2};
         slcfr_pkg::REG_FTYPE: csr_prdata = {24'h0, cfg_ff.ftype};
         slcfr_pkg::REG_PLEN:  csr_prdata = {26'h0, cfg_ff.plen};
         default: csr_prdata = 32'h0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync1 <= slcfr_pkg::SYNC1_RST;
         cfg_ff.sync2 <= slcfr_pkg::SYNC2_RST;
         cfg_ff.ftype <= slcfr_pkg::FTYPE_RST;
         cfg_ff.plen  <= slcfr_pkg::PLEN_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

// ----- src/slcfr_front.sv -----
// ----------------------------------------------------------------------------
// slcfr_front
// Input side: takes received bytes and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none
module slcfr_front (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,
   output logic            q_valid,
   output logic [7:0]      q_data,
   input  wire logic       q_pop
);

   logic [7:0] q_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign req_tready = (cnt_ff != 2'd2);
   assign q_valid = (cnt_ff != 2'd0);
   assign q_data = q_ff[rp_ff];
   assign push = req_tvalid & req_tready;
   assign pop = q_pop & q_valid;

   always_comb begin
      wp_in = push ? ~wp_ff : wp_ff;
      rp_in = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wp_ff] <= req_tdata;
      end
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule
`default_nettype wire

// ----- src/slcfr_back.sv -----
// ----------------------------------------------------------------------------
// slcfr_back
// Frame search engine: circular byte buffer in RAM, rescans from the oldest
// byte, checks sync, type, length and CRC, then streams out the payload.
// ----------------------------------------------------------------------------
`default_nettype none
module slcfr_back #(
   parameter int MAX_PAYLOAD = 32
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire slcfr_pkg::cfg_type cfg,
   input  wire logic       q_valid,
   input  wire logic [7:0] q_data,
   output logic            q_pop,
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [15:0]     rsp_tdata,
   output logic            rsp_tlast
);

   localparam int BUF_LEN = MAX_PAYLOAD + 7;
   localparam int IW = $clog2(BUF_LEN);
   localparam int CW = $clog2(BUF_LEN + 1);

   slcfr_pkg::state_type state_ff, state_in;
   slcfr_pkg::act_type   act;

   logic [IW-1:0] hd_ff, hd_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [15:0]   crc_ff, crc_in;
   logic          tmatch_ff, tmatch_in;
   logic [7:0]    lenlo_ff, lenlo_in;
   logic [7:0]    recvlo_ff, recvlo_in;

   logic          ov_ff, ov_in;
   logic [7:0]    ob_ff, ob_in;
   logic [4:0]    oi_ff, oi_in;
   logic          ol_ff, ol_in;

   logic [6:0]    pl7;
   logic [CW-1:0] flen;
   logic [CW:0]   idx_w;
   logic [7:0]    b;
   logic          out_free;
   logic          full;
   logic          we;
   logic [IW-1:0] waddr, raddr;
   logic [CW:0]   wsum, rsum, dsum;

   // effective payload length, clamped to MAX_PAYLOAD
   assign pl7 = ({1'b0, cfg.plen} > 7'(MAX_PAYLOAD)) ? 7'(MAX_PAYLOAD) : {1'b0, cfg.plen};
   assign flen = CW'(pl7) + CW'(7);
   assign idx_w = (CW+1)'(idx_ff);
   assign out_free = ~ov_ff | rsp_tready;
   assign full = (cnt_ff == CW'(BUF_LEN));

   // buffer write: the new byte lands after the held ones; when full it
   // overwrites the oldest slot and the head moves on
   assign we = (state_ff == slcfr_pkg::ST_IDLE) & q_valid;
   assign q_pop = we;
   assign wsum = (CW+1)'(hd_ff) + (CW+1)'(cnt_ff);
   assign waddr = full ? hd_ff
                : (wsum >= (CW+1)'(BUF_LEN)) ? IW'(wsum - (CW+1)'(BUF_LEN)) : IW'(wsum);
   assign rsum = (CW+1)'(hd_ff) + idx_w;
   assign raddr = (rsum >= (CW+1)'(BUF_LEN)) ? IW'(rsum - (CW+1)'(BUF_LEN)) : IW'(rsum);
   assign dsum = (CW+1)'(hd_ff) + (CW+1)'(flen);

   slcfr_ram #(.WIDTH(8), .DEPTH(BUF_LEN)) u_buf (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (q_data),
      .raddr (raddr),
      .rdata (b)
   );

   // decision for the current cycle
   always_comb begin
      act = slcfr_pkg::ACT_WAIT;
      case (state_ff)
         slcfr_pkg::ST_EVAL: begin
            if (idx_ff == IW'(0)) begin
               if (b != cfg.sync1) act = slcfr_pkg::ACT_DROP;
               else if (cnt_ff == CW'(1)) act = slcfr_pkg::ACT_DONE;
               else act = slcfr_pkg::ACT_NEXT;
            end else if (idx_ff == IW'(1)) begin
               if (b != cfg.sync2) act = slcfr_pkg::ACT_DROP;
               else if (cnt_ff < CW'(5)) act = slcfr_pkg::ACT_DONE;
               else act = slcfr_pkg::ACT_NEXT;
            end else if (idx_ff == IW'(4)) begin
               if (!tmatch_ff || b != 8'h00 || lenlo_ff != 8'(pl7))
                  act = slcfr_pkg::ACT_DROP;
               else if (cnt_ff < flen) act = slcfr_pkg::ACT_DONE;
               else act = slcfr_pkg::ACT_NEXT;
            end else if (idx_w == (CW+1)'(flen) - (CW+1)'(1)) begin
               if ({b, recvlo_ff} != crc_ff) act = slcfr_pkg::ACT_DROP;
               else if (pl7 == 7'd0) act = slcfr_pkg::ACT_REMOVE;
               else act = slcfr_pkg::ACT_EMIT;
            end else begin
               act = slcfr_pkg::ACT_NEXT;
            end
         end
         slcfr_pkg::ST_EOUT: begin
            if (out_free) begin
               if (idx_w == (CW+1)'(flen) - (CW+1)'(3)) act = slcfr_pkg::ACT_REMOVE;
               else act = slcfr_pkg::ACT_NEXT;
            end
         end
         default: act = slcfr_pkg::ACT_WAIT;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         slcfr_pkg::ST_IDLE:  if (q_valid) state_in = slcfr_pkg::ST_SCAN;
         slcfr_pkg::ST_SCAN:  state_in = (cnt_ff == CW'(0)) ? slcfr_pkg::ST_IDLE
                                                             : slcfr_pkg::ST_READ;
         slcfr_pkg::ST_READ:  state_in = slcfr_pkg::ST_EVAL;
         slcfr_pkg::ST_EVAL: begin
            case (act)
               slcfr_pkg::ACT_NEXT:   state_in = slcfr_pkg::ST_READ;
               slcfr_pkg::ACT_DROP:   state_in = slcfr_pkg::ST_SCAN;
               slcfr_pkg::ACT_EMIT:   state_in = slcfr_pkg::ST_EREAD;
               default:               state_in = slcfr_pkg::ST_IDLE;
            endcase
         end
         slcfr_pkg::ST_EREAD: state_in = slcfr_pkg::ST_EOUT;
         slcfr_pkg::ST_EOUT: begin
            case (act)
               slcfr_pkg::ACT_NEXT:   state_in = slcfr_pkg::ST_EREAD;
               slcfr_pkg::ACT_REMOVE: state_in = slcfr_pkg::ST_IDLE;
               default:               state_in = slcfr_pkg::ST_EOUT;
            endcase
         end
         default: state_in = slcfr_pkg::ST_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      hd_in = hd_ff;
      cnt_in = cnt_ff;
      idx_in = idx_ff;
      crc_in = crc_ff;
      tmatch_in = tmatch_ff;
      lenlo_in = lenlo_ff;
      recvlo_in = recvlo_ff;
      ov_in = ov_ff & ~rsp_tready;
      ob_in = ob_ff;
      oi_in = oi_ff;
      ol_in = ol_ff;

      if (we) begin
         if (full) hd_in = (hd_ff == IW'(BUF_LEN - 1)) ? IW'(0) : hd_ff + IW'(1);
         else cnt_in = cnt_ff + CW'(1);
      end
      if (state_ff == slcfr_pkg::ST_SCAN) begin
         idx_in = IW'(0);
         crc_in = slcfr_pkg::CRC_INIT;
      end
      if (state_ff == slcfr_pkg::ST_EVAL) begin
         if (idx_ff == IW'(2)) tmatch_in = (b == cfg.ftype);
         if (idx_ff == IW'(3)) lenlo_in = b;
         if (idx_w == (CW+1)'(flen) - (CW+1)'(2)) recvlo_in = b;
         else if (idx_ff >= IW'(2)) crc_in = slcfr_pkg::crc16_upd(crc_ff, b);
      end
      if (state_ff == slcfr_pkg::ST_EOUT && out_free) begin
         ov_in = 1'b1;
         ob_in = b;
         oi_in = 5'(idx_ff - IW'(5));
         ol_in = (act == slcfr_pkg::ACT_REMOVE);
      end

      case (act)
         slcfr_pkg::ACT_NEXT: idx_in = idx_ff + IW'(1);
         slcfr_pkg::ACT_EMIT: idx_in = IW'(5);
         slcfr_pkg::ACT_DROP: begin
            hd_in = (hd_ff == IW'(BUF_LEN - 1)) ? IW'(0) : hd_ff + IW'(1);
            cnt_in = cnt_ff - CW'(1);
         end
         slcfr_pkg::ACT_REMOVE: begin
            hd_in = (dsum >= (CW+1)'(BUF_LEN)) ? IW'(dsum - (CW+1)'(BUF_LEN)) : IW'(dsum);
            cnt_in = cnt_ff - flen;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      crc_ff <= crc_in;
      tmatch_ff <= tmatch_in;
      lenlo_ff <= lenlo_in;
      recvlo_ff <= recvlo_in;
      idx_ff <= idx_in;
      ob_ff <= ob_in;
      oi_ff <= oi_in;
      ol_ff <= ol_in;
      if (reset) begin
         state_ff <= slcfr_pkg::ST_IDLE;
         hd_ff <= IW'(0);
         cnt_ff <= CW'(0);
         ov_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         hd_ff <= hd_in;
         cnt_ff <= cnt_in;
         ov_ff <= ov_in;
      end
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata = {3'b000, oi_ff, ob_ff};
   assign rsp_tlast = ol_ff;

endmodule
`default_nettype wire

// ----- src/sync_length_crc_frame_receiver.sv -----
// Operation: a byte leaving the input queue is written into the buffer and starts a scan; the
// held bytes are then read and examined one at a time from the oldest on, a full frame check
// covering payload+7 bytes; after a mismatch the oldest byte is dropped and the scan restarts.
// After a passed check each payload byte is read, then registered out and held until taken.
// Throughput: one received byte per search; bytes are taken only in the idle state, not during a search or output.
// Reset: synchronous; empties the buffer and queue, registers take reset values.
// ----------------------------------------------------------------------------
// sync_length_crc_frame_receiver
// Sync/type/length/CRC-16 frame receiver that streams out accepted payloads.
// ----------------------------------------------------------------------------
`default_nettype none
module sync_length_crc_frame_receiver #(
   parameter int MAX_PAYLOAD = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [7:0] payload_byte, [12:8] byte_index
   output logic             rsp_tlast,   // last_byte
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready
);

   slcfr_pkg::cfg_type cfg;
   logic       q_valid, q_pop;
   logic [7:0] q_data;

   slcfr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   slcfr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_valid    (q_valid),
      .q_data     (q_data),
      .q_pop      (q_pop)
   );

   slcfr_back #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .q_valid    (q_valid),
      .q_data     (q_data),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire
